// File: design/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Types and constants shared by the cursor byte buffer engine.
// ----------------------------------------------------------------------------
package cbb_pkg;

    localparam int CAPACITY = 256;
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int SEEK_W   = 9;
    localparam int CNT_W    = 9;
    localparam int SUM_W    = (PTR_W + 1 > SEEK_W) ? PTR_W + 1 : SEEK_W;
    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int ROWS     = (CAPACITY + LANES - 1) / LANES;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_READ_PAST_END = 2'd1,
        ST_NO_ROOM       = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [1:0]         size_code;
        logic               big_endian;
        logic [63:0]        write_value;
        logic [SEEK_W-1:0]  seek_target;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        read_value;
        logic [CNT_W-1:0]   cursor;
        logic [CNT_W-1:0]   length;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic [LANES-1:0]             we;
        logic [LANES-1:0][ROW_W-1:0]  row;
        logic [LANES-1:0][7:0]        wdata;
    } t_bank_req;

    typedef struct packed {
        logic               vld;
        logic               rd_ok;
        logic [LANE_W-1:0]  base;
        logic [LANE_W-1:0]  last;
        logic               big;
        logic [CNT_W-1:0]   cursor;
        logic [CNT_W-1:0]   length;
        t_status            status;
    } t_align;

endpackage

// File: design/cbb_byte_banks.sv
// ----------------------------------------------------------------------------
// cbb_byte_banks
// Eight byte-wide banks; one write and one registered read per bank a cycle.
// ----------------------------------------------------------------------------
module cbb_byte_banks (
    input  logic                                  i_clk,
    input  cbb_pkg::t_bank_req                    i_req,
    output logic [cbb_pkg::LANES-1:0][7:0]        o_rdata
);

    for (genvar b = 0; b < cbb_pkg::LANES; b++) begin : g_bank
        logic [7:0] mem [cbb_pkg::ROWS];
        logic [7:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_req.we[b]) begin
                mem[i_req.row[b]] <= i_req.wdata[b];
            end
            r_q <= mem[i_req.row[b]];
        end

        assign o_rdata[b] = r_q;
    end

endmodule

// File: design/cbb_ctrl.sv
// ----------------------------------------------------------------------------
// cbb_ctrl
// Input register, cursor and length state, bank addressing and byte steering.
// ----------------------------------------------------------------------------
module cbb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cbb_pkg::t_in_item    i_item,
    output cbb_pkg::t_bank_req   o_bank_req,
    output cbb_pkg::t_align      o_align
);

    logic                               r_in_vld;
    cbb_pkg::t_in_item                  r_in;
    logic [cbb_pkg::PTR_W-1:0]          r_cursor;
    logic [cbb_pkg::PTR_W-1:0]          n_cursor;
    logic [cbb_pkg::PTR_W-1:0]          r_length;
    logic [cbb_pkg::PTR_W-1:0]          n_length;
    cbb_pkg::t_status                   n_status;
    cbb_pkg::t_align                    r_align;
    logic [cbb_pkg::LANE_W-1:0]         last;
    logic [cbb_pkg::SUM_W-1:0]          end_pos;
    logic                               wr_ok;
    logic                               rd_ok;
    logic [cbb_pkg::LANES-1:0][cbb_pkg::LANE_W-1:0] off;
    logic [cbb_pkg::LANES-1:0][cbb_pkg::LANE_W-1:0] lane;
    logic [cbb_pkg::LANES-1:0][cbb_pkg::SUM_W-1:0]  addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start;
        end
        r_in <= i_item;
    end

    always_comb begin
        case (r_in.size_code)
            2'd0:    last = cbb_pkg::LANE_W'(0);
            2'd1:    last = cbb_pkg::LANE_W'(1);
            2'd2:    last = cbb_pkg::LANE_W'(3);
            default: last = cbb_pkg::LANE_W'(7);
        endcase
    end

    assign end_pos = cbb_pkg::SUM_W'(r_cursor) + cbb_pkg::SUM_W'(last) + 1'b1;
    assign wr_ok   = (r_in.op == cbb_pkg::OP_WRITE) &&
                     (end_pos <= cbb_pkg::SUM_W'(cbb_pkg::CAPACITY));
    assign rd_ok   = (r_in.op == cbb_pkg::OP_READ) &&
                     (end_pos <= cbb_pkg::SUM_W'(r_length));

    always_comb begin
        n_cursor = r_cursor;
        n_length = r_length;
        n_status = cbb_pkg::ST_OK;
        case (r_in.op)
            cbb_pkg::OP_WRITE: begin
                if (wr_ok) begin
                    n_cursor = cbb_pkg::PTR_W'(end_pos);
                    if (cbb_pkg::PTR_W'(end_pos) > r_length) begin
                        n_length = cbb_pkg::PTR_W'(end_pos);
                    end
                end else begin
                    n_status = cbb_pkg::ST_NO_ROOM;
                end
            end
            cbb_pkg::OP_READ: begin
                if (rd_ok) begin
                    n_cursor = cbb_pkg::PTR_W'(end_pos);
                end else begin
                    n_status = cbb_pkg::ST_READ_PAST_END;
                end
            end
            cbb_pkg::OP_SEEK: begin
                if (cbb_pkg::SUM_W'(r_in.seek_target) > cbb_pkg::SUM_W'(r_length)) begin
                    n_cursor = r_length;
                end else begin
                    n_cursor = cbb_pkg::PTR_W'(r_in.seek_target);
                end
            end
            default: begin
                n_cursor = '0;
                n_length = '0;
            end
        endcase
    end

    always_comb begin
        for (int b = 0; b < cbb_pkg::LANES; b++) begin
            off[b]  = cbb_pkg::LANE_W'(b) - r_cursor[cbb_pkg::LANE_W-1:0];
            lane[b] = r_in.big_endian ? (last - off[b]) : off[b];
            addr[b] = cbb_pkg::SUM_W'(r_cursor) + cbb_pkg::SUM_W'(off[b]);
            o_bank_req.we[b]    = r_in_vld && wr_ok && (off[b] <= last);
            o_bank_req.row[b]   = cbb_pkg::ROW_W'(addr[b] >> cbb_pkg::LANE_W);
            o_bank_req.wdata[b] = r_in.write_value[8*lane[b] +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_length    <= '0;
            r_align.vld <= 1'b0;
        end else begin
            r_align.vld <= r_in_vld;
            if (r_in_vld) begin
                r_cursor <= n_cursor;
                r_length <= n_length;
            end
        end
        r_align.rd_ok  <= rd_ok;
        r_align.base   <= r_cursor[cbb_pkg::LANE_W-1:0];
        r_align.last   <= last;
        r_align.big    <= r_in.big_endian;
        r_align.cursor <= cbb_pkg::CNT_W'(n_cursor);
        r_align.length <= cbb_pkg::CNT_W'(n_length);
        r_align.status <= n_status;
    end

    assign o_align = r_align;

endmodule

// File: design/cbb_read_align.sv
// ----------------------------------------------------------------------------
// cbb_read_align
// Gathers bank bytes into the read value and holds the result register.
// ----------------------------------------------------------------------------
module cbb_read_align (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cbb_pkg::t_align                       i_align,
    input  logic [cbb_pkg::LANES-1:0][7:0]        i_rdata,
    output logic                                  o_valid,
    output cbb_pkg::t_result                      o_result
);

    logic [cbb_pkg::LANES-1:0][7:0]           bytes;
    logic [cbb_pkg::LANES-1:0][cbb_pkg::LANE_W-1:0] off;
    logic                                     r_valid;
    cbb_pkg::t_result                         r_result;

    always_comb begin
        for (int k = 0; k < cbb_pkg::LANES; k++) begin
            off[k] = i_align.big ? (i_align.last - cbb_pkg::LANE_W'(k))
                                 : cbb_pkg::LANE_W'(k);
            if (i_align.rd_ok && (cbb_pkg::LANE_W'(k) <= i_align.last)) begin
                bytes[k] = i_rdata[i_align.base + off[k]];
            end else begin
                bytes[k] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_align.vld;
        end
        r_result.read_value <= bytes;
        r_result.cursor     <= i_align.cursor;
        r_result.length     <= i_align.length;
        r_result.status     <= i_align.status;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/cursor_byte_buffer_engine_top.sv
// ----------------------------------------------------------------------------
// cursor_byte_buffer_engine_top
// Byte buffer with a cursor, high-water length and typed endian access.
// ----------------------------------------------------------------------------
// One transaction is taken in every cycle; busy is high only while reset is
// held. Each transaction gives one result, strobed on o_valid for one cycle,
// after the input, align and result registers. The receiver cannot stall.
// The rate is set by the store: eight byte-wide banks, each with one write
// and one registered read port, so any access of up to eight bytes at any
// cursor touches each bank at most once in a single cycle.
module cursor_byte_buffer_engine_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cbb_pkg::t_in_item    i_item,
    output logic                 o_valid,
    output cbb_pkg::t_result     o_result
);

    cbb_pkg::t_bank_req                   bank_req;
    cbb_pkg::t_align                      align;
    logic [cbb_pkg::LANES-1:0][7:0]       rdata;

    assign busy = ~i_rst_n;

    cbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_bank_req (bank_req),
        .o_align    (align)
    );

    cbb_byte_banks u_banks (
        .i_clk   (i_clk),
        .i_req   (bank_req),
        .o_rdata (rdata)
    );

    cbb_read_align u_align (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_align  (align),
        .i_rdata  (rdata),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result strobe missing three cycles after transaction");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != cbb_pkg::ST_OK)) |-> (o_result.read_value == 64'd0))
        else $error("failed transaction returned nonzero read value");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.cursor <= o_result.length))
        else $error("cursor beyond length");

    a_write_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_req.we != '0) |=> (align.vld && (align.status == cbb_pkg::ST_OK)))
        else $error("bank write without a successful transaction");

endmodule
